### rtl/gdad_pkg.sv
// gdad_pkg: constants, step tables and helpers for the gregorian date adder
// no dependencies; imported by the top level and its checker
`timescale 1ns / 1ps
`default_nettype none

package gdad_pkg;

    // largest year that can be given out
    localparam int LAST_YEAR = 9999;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int OFFSET_W = 23;
    localparam int NUM_W    = 24;   // day numbers and remainders
    localparam int SUM_W    = NUM_W + 2;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    localparam int N_STEPS = 16;
    localparam int STEP_W  = 4;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(N_STEPS - 1);

    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

    // year weights of the 400, 100, 4 and 1 year blocks, high bit first
    localparam logic [NUM_W-1:0] YEAR_STEP [N_STEPS] = '{
        24'd25600, 24'd12800, 24'd6400, 24'd3200, 24'd1600, 24'd800, 24'd400,
        24'd200, 24'd100,
        24'd64, 24'd32, 24'd16, 24'd8, 24'd4,
        24'd2, 24'd1
    };

    // day counts of the same blocks
    localparam logic [NUM_W-1:0] DAY_STEP [N_STEPS] = '{
        24'd9350208, 24'd4675104, 24'd2337552, 24'd1168776, 24'd584388,
        24'd292194, 24'd146097,
        24'd73048, 24'd36524,
        24'd23376, 24'd11688, 24'd5844, 24'd2922, 24'd1461,
        24'd730, 24'd365
    };

    localparam logic [8:0] CUM_DAYS [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // leap test of year p+1 from the block digits of p
    function automatic logic leap_of(input logic [1:0] q100, input logic [4:0] q4,
                                     input logic [1:0] q1);
        return (q1 == 2'd3) && ((q4 != 5'd24) || (q100 == 2'd3));
    endfunction

endpackage

`default_nettype wire

### rtl/gregorian_date_add_days_top.sv
// gregorian_date_add_days_top: adds a signed day offset to a gregorian date
// depends on gdad_pkg
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   slave stream (i_s_axis_*) takes one date plus a signed day offset per
//   transaction; master stream (o_m_axis_*) gives one result per input.
//   The date is turned into a day number, the offset is added and the sum
//   is split back into year, month and day. A single subtract-compare unit
//   walks 16 steps over the 400, 100, 4 and 1 year blocks, once forward and
//   once in reverse; the months are then walked in 1 to 12 steps.
//   A sum before year 1 skips the reverse walk and the months, and a year
//   past LAST_YEAR skips the months. One item is in work at a time: the
//   next input is accepted only after the sequencer has passed its result
//   to the output register.
//   o_s_axis_tready is high only while the sequencer is idle.
//   The result sits in an output register: the next item may be accepted
//   while it waits, and the sequencer holds its finished result when the
//   receiver stalls until the output register frees up.
//   Results before year 1 or past LAST_YEAR give zero date fields and set
//   tuser. Synchronous active-low reset returns the sequencer to idle and
//   drops o_m_axis_tvalid.

module gregorian_date_add_days_top
    import gdad_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // day_in[4:0], month_in[8:5], year_in[22:9], offset_days[45:23], zero pad
    input  wire [IN_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    // day_out[4:0], month_out[8:5], year_out[22:9], zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // out_of_range[0]
    output logic [0:0]             o_m_axis_tuser
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FWD   = 8'b0000_0010,
        S_ADJ   = 8'b0000_0100,
        S_SUM   = 8'b0000_1000,
        S_REV   = 8'b0001_0000,
        S_YCHK  = 8'b0010_0000,
        S_MONTH = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [NUM_W-1:0]           r_rem, n_rem;
    logic [NUM_W-1:0]           r_acc, n_acc;
    logic [STEP_W-1:0]          r_step, n_step;
    logic [1:0]                 r_q100, n_q100;
    logic [4:0]                 r_q4, n_q4;
    logic [1:0]                 r_q1, n_q1;
    logic [DAY_W-1:0]           r_day, n_day;
    logic [MONTH_W-1:0]         r_mon, n_mon;
    logic signed [OFFSET_W-1:0] r_off, n_off;

    logic [DAY_W-1:0]           r_res_day, n_res_day;
    logic [MONTH_W-1:0]         r_res_mon, n_res_mon;
    logic [YEAR_W-1:0]          r_res_year, n_res_year;
    logic                       r_res_oor, n_res_oor;

    logic                       r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0]     r_out_data, n_out_data;
    logic                       r_out_oor, n_out_oor;

    // input fields
    logic [DAY_W-1:0]    in_day;
    logic [MONTH_W-1:0]  in_mon;
    logic [YEAR_W-1:0]   in_year;
    logic [MONTH_W-1:0]  mon_clamp;
    logic [YEAR_W-1:0]   year_clamp;

    // shared subtract-compare unit
    logic [NUM_W-1:0]    unit_div;
    logic [NUM_W-1:0]    unit_wt;
    logic                unit_take;
    logic [NUM_W-1:0]    unit_diff;

    logic                is_leap;
    logic [3:0]          mon_idx;
    logic [DAY_W:0]      mon_len;
    logic signed [SUM_W-1:0] day_sum;
    logic [NUM_W-1:0]    year_calc;
    logic                out_free;

    assign in_day  = i_s_axis_tdata[4:0];
    assign in_mon  = i_s_axis_tdata[8:5];
    assign in_year = i_s_axis_tdata[22:9];

    always_comb begin
        if (in_mon == '0) begin
            mon_clamp = JANUARY;
        end else if (in_mon > DECEMBER) begin
            mon_clamp = DECEMBER;
        end else begin
            mon_clamp = in_mon;
        end
        year_clamp = (in_year == '0) ? YEAR_W'(1) : in_year;
    end

    // forward: remainder in years, weight in days; reverse the other way
    always_comb begin
        if (r_state == S_FWD) begin
            unit_div = YEAR_STEP[r_step];
            unit_wt  = DAY_STEP[r_step];
        end else begin
            unit_div = DAY_STEP[r_step];
            unit_wt  = YEAR_STEP[r_step];
        end
        unit_take = (r_rem >= unit_div);
        unit_diff = r_rem - unit_div;
    end

    assign is_leap   = leap_of(r_q100, r_q4, r_q1);
    assign mon_idx   = r_mon - 4'd1;
    assign mon_len   = {1'b0, MONTH_LEN[mon_idx]}
                     + {{DAY_W{1'b0}}, ((r_mon == FEBRUARY) && is_leap)};
    assign day_sum   = $signed({2'b00, r_acc}) + {{(SUM_W-OFFSET_W){r_off[OFFSET_W-1]}}, r_off}
                     - SUM_W'(1);
    assign year_calc = r_acc + NUM_W'(1);
    assign out_free  = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_rem      = r_rem;
        n_acc      = r_acc;
        n_step     = r_step;
        n_q100     = r_q100;
        n_q4       = r_q4;
        n_q1       = r_q1;
        n_day      = r_day;
        n_mon      = r_mon;
        n_off      = r_off;
        n_res_day  = r_res_day;
        n_res_mon  = r_res_mon;
        n_res_year = r_res_year;
        n_res_oor  = r_res_oor;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_oor   = r_out_oor;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_rem   = NUM_W'(year_clamp - YEAR_W'(1));
                    n_acc   = '0;
                    n_step  = '0;
                    n_q100  = '0;
                    n_q4    = '0;
                    n_q1    = '0;
                    n_day   = in_day;
                    n_mon   = mon_clamp;
                    n_off   = i_s_axis_tdata[45:23];
                    n_state = S_FWD;
                end
            end
            S_FWD, S_REV: begin
                if (unit_take) begin
                    n_rem = unit_diff;
                    n_acc = r_acc + unit_wt;
                end
                case (r_step) inside
                    [4'd7:4'd8]:   n_q100 = {r_q100[0], unit_take};
                    [4'd9:4'd13]:  n_q4   = {r_q4[3:0], unit_take};
                    [4'd14:4'd15]: n_q1   = {r_q1[0], unit_take};
                    default:       n_q100 = r_q100;
                endcase
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_state = (r_state == S_FWD) ? S_ADJ : S_YCHK;
                end
            end
            S_ADJ: begin
                n_acc = r_acc + NUM_W'(CUM_DAYS[mon_idx])
                      + NUM_W'((r_mon > FEBRUARY) && is_leap) + NUM_W'(r_day);
                n_state = S_SUM;
            end
            S_SUM: begin
                // zero-based day number; negative means before year 1
                if (day_sum[SUM_W-1]) begin
                    n_res_day  = '0;
                    n_res_mon  = '0;
                    n_res_year = '0;
                    n_res_oor  = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    n_rem   = day_sum[NUM_W-1:0];
                    n_acc   = '0;
                    n_step  = '0;
                    n_q100  = '0;
                    n_q4    = '0;
                    n_q1    = '0;
                    n_state = S_REV;
                end
            end
            S_YCHK: begin
                if (year_calc > NUM_W'(LAST_YEAR)) begin
                    n_res_day  = '0;
                    n_res_mon  = '0;
                    n_res_year = '0;
                    n_res_oor  = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    n_res_year = year_calc[YEAR_W-1:0];
                    n_mon      = JANUARY;
                    n_state    = S_MONTH;
                end
            end
            S_MONTH: begin
                if ((r_rem < NUM_W'(mon_len)) || (r_mon == DECEMBER)) begin
                    n_res_day = r_rem[DAY_W-1:0] + DAY_W'(1);
                    n_res_mon = r_mon;
                    n_res_oor = 1'b0;
                    n_state   = S_EMIT;
                end else begin
                    n_rem = r_rem - NUM_W'(mon_len);
                    n_mon = r_mon + MONTH_W'(1);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_res_year, r_res_mon, r_res_day};
                    n_out_oor   = r_res_oor;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem      <= n_rem;
        r_acc      <= n_acc;
        r_step     <= n_step;
        r_q100     <= n_q100;
        r_q4       <= n_q4;
        r_q1       <= n_q1;
        r_day      <= n_day;
        r_mon      <= n_mon;
        r_off      <= n_off;
        r_res_day  <= n_res_day;
        r_res_mon  <= n_res_mon;
        r_res_year <= n_res_year;
        r_res_oor  <= n_res_oor;
        r_out_data <= n_out_data;
        r_out_oor  <= n_out_oor;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_oor;

endmodule

`default_nettype wire

### rtl/gdad_checker.sv
// gdad_checker: port-level assertions for the gregorian date adder
// depends on gdad_pkg; bound to gregorian_date_add_days_top
`timescale 1ns / 1ps
`default_nettype none

module gdad_checker
    import gdad_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_s_tvalid,
    input wire                   i_s_tready,
    input wire                   i_m_tvalid,
    input wire                   i_m_tready,
    input wire [OUT_TDATA_W-1:0] i_m_tdata,
    input wire [0:0]             i_m_tuser
);

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("input accepted while an item is in work");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser[0]) |-> (i_m_tdata == '0))
        else $error("out of range result with nonzero date");

    a_date_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tuser[0]) |->
            (i_m_tdata[8:5] != 4'd0) && (i_m_tdata[8:5] <= 4'd12)
            && (i_m_tdata[4:0] != 5'd0) && (i_m_tdata[22:9] != 14'd0)
            && (32'(i_m_tdata[22:9]) <= LAST_YEAR) && (i_m_tdata[23] == 1'b0))
        else $error("result date fields out of their ranges");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
            (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("stalled result changed or dropped");

endmodule

bind gregorian_date_add_days_top gdad_checker u_gdad_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

`default_nettype wire
